[design/rvdq_pkg.sv]
// ---------------------------------------------------------------------------
// rvdq_pkg: shared types and codes for the reversible deque
// Request and result beat layouts, request and status codes, and the
// per-cycle command that steers the row of storage cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvdq_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_TOGGLE     = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

  // input beat
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] data_in;
  } rvdq_req_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         count;
    logic [1:0]         status;
  } rvdq_rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push_head;  // shift toward the tail, new word enters cell 0
    logic pop_head;   // shift toward the head
    logic push_tail;  // write new word into the first free cell
  } rvdq_cmd_t;

endpackage

[design/rvdq_cell.sv]
// ---------------------------------------------------------------------------
// rvdq_cell: one storage slot of the deque row
// Holds one word, takes its neighbor's word on head push/pop, accepts the
// new word on a tail push, and folds its word into the tail-read chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvdq_cell
  import rvdq_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  rvdq_cmd_t             cmd,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] tail_acc_in,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [DATA_WIDTH-1:0] tail_acc_out
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  is_tail;
  logic                  is_free_slot;

  assign is_free_slot = (cnt == CNT_W'(IDX));
  assign is_tail      = (cnt == CNT_W'(IDX + 1));

  // slot update
  always_comb begin
    data_nxt = data_r;
    if (cmd.push_head) begin
      data_nxt = left_word;
    end else if (cmd.pop_head) begin
      data_nxt = right_word;
    end else if (cmd.push_tail && is_free_slot) begin
      data_nxt = push_word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // tail read chain: only the tail slot contributes
  assign tail_acc_out = tail_acc_in | (is_tail ? data_r : '0);
  assign data_out     = data_r;

endmodule

[design/reversible_deque.sv]
// ---------------------------------------------------------------------------
// reversible_deque: bounded double-ended queue with direction flip
// Row of DEPTH cells, physical head in cell 0, plus count and direction.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry request beats (push front/back, pop
//   front/back, toggle direction). Each accepted request yields exactly one
//   beat on out_valid/out_stall/out_data with the logical front and back
//   words (all ones when empty), the element count and a status code.
//   An accepted request updates the cell row, count and direction; its
//   result is then read (head slot plus tail-read chain) and registered.
//   No new request is accepted while a result is still pending.
//   A push on a full queue or a pop on an empty one leaves the state
//   unchanged and is flagged in the status field.
//   While out_stall is high the result beat holds and in_stall stays high,
//   so no request is lost. Reset (rst_n low, synchronous) empties the
//   queue and clears the direction; cell contents are not cleared and are
//   never shown before being written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module reversible_deque
  import rvdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rvdq_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rvdq_rsp_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // control state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  logic             pend_r, pend_nxt;
  logic [1:0]       pend_st_r, pend_st_nxt;
  logic             out_valid_r, out_valid_nxt;
  rvdq_rsp_t        out_r, out_nxt;

  logic             accept;
  logic             out_load;
  logic             is_push, is_pop, is_toggle;
  logic             full, empty;
  logic             at_head_push, at_head_pop;
  rvdq_cmd_t        cmd;
  logic [63:0]      din64;
  logic [DATA_WIDTH-1:0] push_word;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] tail_acc  [DEPTH+1];

  logic [DATA_WIDTH-1:0] head_w, tail_w, front_w, back_w;
  logic [63:0]           front64, back64;

  // handshake
  assign in_stall  = pend_r | (out_valid_r & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign out_load  = pend_r & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // request decode
  assign is_push   = (in_data.req_type == REQ_PUSH_FRONT) ||
                     (in_data.req_type == REQ_PUSH_BACK);
  assign is_pop    = (in_data.req_type == REQ_POP_FRONT) ||
                     (in_data.req_type == REQ_POP_BACK);
  assign is_toggle = (in_data.req_type == REQ_TOGGLE);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);

  // reversal swaps which physical end a front/back request touches
  assign at_head_push = (in_data.req_type == REQ_PUSH_FRONT) ^ rev_r;
  assign at_head_pop  = (in_data.req_type == REQ_POP_FRONT) ^ rev_r;

  assign cmd.push_head = accept & is_push & ~full & at_head_push;
  assign cmd.push_tail = accept & is_push & ~full & ~at_head_push;
  assign cmd.pop_head  = accept & is_pop & ~empty & at_head_pop;

  assign din64     = {32'b0, in_data.data_in};
  assign push_word = din64[DATA_WIDTH-1:0];

  // cell row
  assign tail_acc[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = push_word;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    rvdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .cnt          (cnt_r),
      .push_word    (push_word),
      .left_word    (left_w),
      .right_word   (right_w),
      .tail_acc_in  (tail_acc[i+1]),
      .data_out     (cell_data[i]),
      .tail_acc_out (tail_acc[i])
    );
  end

  // count, direction and pending status
  always_comb begin
    cnt_nxt     = cnt_r;
    rev_nxt     = rev_r;
    pend_st_nxt = pend_st_r;
    pend_nxt    = pend_r;
    if (out_load) begin
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt    = 1'b1;
      pend_st_nxt = ST_DONE;
      if (is_push) begin
        if (full) begin
          pend_st_nxt = ST_PUSH_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end else if (is_pop) begin
        if (empty) begin
          pend_st_nxt = ST_POP_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end else if (is_toggle) begin
        rev_nxt = ~rev_r;
      end
    end
  end

  // result assembly from the updated row
  assign head_w  = cell_data[0];
  assign tail_w  = tail_acc[0];
  assign front_w = empty ? {DATA_WIDTH{1'b1}} : (rev_r ? tail_w : head_w);
  assign back_w  = empty ? {DATA_WIDTH{1'b1}} : (rev_r ? head_w : tail_w);
  assign front64 = 64'(front_w);
  assign back64  = 64'(back_w);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt       = 1'b1;
      out_nxt.front_value = front64[31:0];
      out_nxt.back_value  = back64[31:0];
      out_nxt.count       = 5'(cnt_r);
      out_nxt.status      = pend_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_st_r <= pend_st_nxt;
    out_r     <= out_nxt;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_load_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> pend_r && !accept)
    else $error("result loaded without a pending request");

  a_full_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_push && full |=> cnt_r == $past(cnt_r) && pend_st_r == ST_PUSH_FULL)
    else $error("push on full changed the count");

  a_empty_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_pop && empty |=> cnt_r == '0 && pend_st_r == ST_POP_EMPTY)
    else $error("pop on empty changed the count");

  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_toggle |=> rev_r != $past(rev_r))
    else $error("toggle did not flip the direction");

endmodule

[test/reversible_deque_tb.sv]
// ---------------------------------------------------------------------------
// reversible_deque_tb: self-checking bench for the reversible deque
// Drives request beats through the valid/stall input channel, predicts each
// result beat with a behavioral deque (ring, head, fill, direction flag) and
// compares every returned beat field by field against the oldest prediction.
// Covers empty pops, full pushes, direction flips, unused codes, random
// fill/drain bursts, long receiver hold-offs and sender pauses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module reversible_deque_tb;
  import rvdq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 60;
  localparam int RANDOM_ITEMS  = 460;

  // request codes the block must treat as no-ops
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rvdq_req_t in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rvdq_rsp_t out_data;

  // behavioral deque state
  logic signed [31:0] ring_q [DEPTH];
  int                 head_pos;
  int                 fill;
  bit                 flipped;

  rvdq_rsp_t snapshot_q [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rx_hold      = 0;
  int errors       = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_dropped    = 0;
  int n_empty_pops = 0;
  int n_flips      = 0;
  int peak_fill    = 0;
  int quiet_cycles = 0;

  reversible_deque i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Apply one request to the deque and return the result beat it yields
  function automatic rvdq_rsp_t apply_request(input rvdq_req_t r);
    rvdq_rsp_t          rsp;
    bit                 at_head;
    logic signed [31:0] head_w;
    logic signed [31:0] tail_w;
    rsp.status = ST_DONE;
    if (r.req_type == REQ_PUSH_FRONT || r.req_type == REQ_PUSH_BACK) begin
      if (fill == DEPTH) begin
        rsp.status = ST_PUSH_FULL;
        n_dropped++;
      end else begin
        // front means physical head unless the direction is flipped
        at_head = (r.req_type == REQ_PUSH_FRONT) ^ flipped;
        if (at_head) begin
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
          ring_q[head_pos] = r.data_in;
        end else begin
          ring_q[(head_pos + fill) % DEPTH] = r.data_in;
        end
        fill++;
      end
    end else if (r.req_type == REQ_POP_FRONT || r.req_type == REQ_POP_BACK) begin
      if (fill == 0) begin
        rsp.status = ST_POP_EMPTY;
        n_empty_pops++;
      end else begin
        at_head = (r.req_type == REQ_POP_FRONT) ^ flipped;
        if (at_head) head_pos = (head_pos + 1) % DEPTH;
        fill--;
      end
    end else if (r.req_type == REQ_TOGGLE) begin
      flipped = ~flipped;
      n_flips++;
    end
    if (fill > peak_fill) peak_fill = fill;

    if (fill == 0) begin
      rsp.front_value = -32'sd1;
      rsp.back_value  = -32'sd1;
    end else begin
      head_w = ring_q[head_pos];
      tail_w = ring_q[(head_pos + fill - 1) % DEPTH];
      rsp.front_value = flipped ? tail_w : head_w;
      rsp.back_value  = flipped ? head_w : tail_w;
    end
    rsp.count = 5'(fill);
    return rsp;
  endfunction

  // Offer one request beat, hold it until taken, then record its prediction
  task automatic send_req(input logic [2:0] code, input logic signed [31:0] word);
    rvdq_req_t r;
    r.req_type = code;
    r.data_in  = word;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    snapshot_q.insert(snapshot_q.size(), apply_request(r));
    n_requests++;
  endtask

  // Sender goes quiet until every predicted beat has come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (snapshot_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result beat checker
  always @(posedge clk) begin
    rvdq_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (snapshot_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got front %0d back %0d",
                 $time, out_data.front_value, out_data.back_value);
        errors++;
      end else begin
        // oldest prediction first
        want = snapshot_q[0];
        snapshot_q.delete(0);
        check_field("front_value", want.front_value, out_data.front_value);
        check_field("back_value", want.back_value, out_data.back_value);
        check_field("count", 32'(want.count), 32'(out_data.count));
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // Receiver stall: a long hold when requested, random stalls otherwise
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold   <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: timeout, %0d results outstanding", $time, snapshot_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Empty-queue pops, flips on empty, extremes, unused codes, fill to full
  task automatic test_edges();
    int c;
    send_req(REQ_POP_FRONT, 32'sd5);
    send_req(REQ_POP_BACK, -32'sd5);
    send_req(REQ_TOGGLE, 32'sd0);
    send_req(REQ_PUSH_FRONT, 32'sh7FFFFFFF);
    send_req(REQ_PUSH_BACK, 32'sh80000000);
    send_req(REQ_TOGGLE, -32'sd1);
    for (c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++) send_req(3'(c), 32'(c));
    send_req(REQ_PUSH_FRONT, 32'sd0);
    send_req(REQ_PUSH_BACK, -32'sd1);
    // top up to full with alternating ends
    for (c = 0; c < DEPTH - 4; c++)
      send_req((c % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, 32'($urandom));
    send_req(REQ_PUSH_FRONT, 32'sh5A5A5A5A);
    send_req(REQ_PUSH_BACK, 32'shA5A5A5A5);
  endtask

  // Receiver holds off while pops keep coming, then the sender pauses
  task automatic test_backpressure();
    int saved;
    int k;
    saved = snd_idle_pct;
    snd_idle_pct = 0;
    rx_hold = HOLD_CYCLES;
    for (k = 0; k < DEPTH + 2; k++)
      send_req((k % 3 == 0) ? REQ_POP_BACK : REQ_POP_FRONT, 32'($urandom));
    snd_idle_pct = saved;
    wait_all_results();
    send_req(REQ_PUSH_BACK, 32'sd1);
    send_req(REQ_TOGGLE, 32'sd0);
    send_req(REQ_POP_FRONT, 32'sd0);
  endtask

  // Fill-biased and drain-biased bursts of random requests
  task automatic test_random_traffic(input int n_items);
    int                 left;
    int                 burst;
    int                 pick;
    int                 push_pct;
    logic [2:0]         code;
    logic signed [31:0] word;
    left = n_items;
    while (left > 0) begin
      push_pct = $urandom_range(1) ? 65 : 25;
      burst = $urandom_range(40, 6);
      while (burst > 0 && left > 0) begin
        pick = $urandom_range(99);
        if (pick < 3) code = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
        else if (pick < 10) code = REQ_TOGGLE;
        else if (pick < 10 + push_pct)
          code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        else code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        case ($urandom_range(9))
          0:       word = 32'sh7FFFFFFF;
          1:       word = 32'sh80000000;
          2:       word = -32'sd1;
          3:       word = 32'($urandom_range(15));
          default: word = 32'($urandom);
        endcase
        send_req(code, word);
        burst--;
        left--;
      end
    end
  endtask

  initial begin
    head_pos = 0;
    fill     = 0;
    flipped  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 28;
    rcv_idle_pct = 69;
    test_edges();
    test_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    snd_idle_pct = 69;
    rcv_idle_pct = 28;
    test_random_traffic(RANDOM_ITEMS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS);

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (snapshot_q.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, snapshot_q.size());
      errors++;
    end

    $display("Ran %0d requests, checked %0d results, %0d mismatches.",
             n_requests, n_results, errors);
    $display("Seen: %0d full-queue drops, %0d empty pops, %0d flips, peak fill %0d.",
             n_dropped, n_empty_pops, n_flips, peak_fill);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rvdq_pkg.sv
design/rvdq_cell.sv
design/reversible_deque.sv
test/reversible_deque_tb.sv
